### src/ltw_pkg.sv
package ltw_pkg;

  localparam int NUM_LOCKS   = 64;
  localparam int NUM_CLIENTS = 16;
  localparam int LOCK_W      = 6;
  localparam int CLIENT_W    = 4;

  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RETRY = 1'b1;

  typedef enum logic [1:0] {
    MSG_NONE   = 2'd0,
    MSG_REVOKE = 2'd1,
    MSG_RETRY  = 2'd2
  } msg_t;

  typedef struct packed {
    logic                action;
    logic [LOCK_W-1:0]   lock_index;
    logic [CLIENT_W-1:0] client;
  } req_t;

  typedef struct packed {
    logic                status;
    msg_t                message;
    logic [CLIENT_W-1:0] target;
  } rsp_t;

  typedef struct packed {
    logic                   locked;
    logic                   holder_valid;
    logic [CLIENT_W-1:0]    holder;
    logic                   retry_valid;
    logic [CLIENT_W-1:0]    retry;
    logic [NUM_CLIENTS-1:0] waiters;
  } entry_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  function automatic logic [CLIENT_W-1:0] lowest_waiter(input logic [NUM_CLIENTS-1:0] w);
    logic [CLIENT_W-1:0] r;
    r = '0;
    for (int i = NUM_CLIENTS - 1; i >= 0; i--) begin
      if (w[i]) r = CLIENT_W'(i);
    end
    return r;
  endfunction

endpackage

### src/lock_table_with_waiters.sv
// lock manager over a table of 64 locks, each with a holder, a designated
// retry client and a set of waiting clients (16 clients). a request item is an
// acquire or a release of one lock by one client; every request gives exactly
// one response item: status ok or retry, plus an optional message (revoke to
// the holder, or retry to the designated waiter) and its target client.
// responses come back in request order. each request has a read step, which
// reads the lock entry from the table memory (registered read), then an update
// step, which updates it, writes it back and loads the response register; the
// next request is taken in the following cycle, so a new request is not taken
// before the last one is updated. a response waiting in its register does not
// block the next request from being read; only its update waits for the
// register to empty. after reset every lock reads as unlocked with no holder
// and no waiters, with no clearing pass. indexes or clients out of range
// change nothing and answer retry with no message.
module lock_table_with_waiters
  import ltw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // command bundle from the sequencer to the table datapath
  cmd_t cmd;

  // sequencer: request handshake, read then update step, response register valid
  ltw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // datapath: lock table memory, entry update logic, response register
  ltw_dp u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

### src/ltw_ctrl.sv
module ltw_ctrl
  import ltw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  output logic rsp_valid,
  input  logic rsp_stall,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_full, out_full_next;
  logic   take;

  assign take      = out_full && !rsp_stall;
  assign rsp_valid = out_full;

  always_comb begin
    state_next    = state;
    out_full_next = out_full && !take;
    cmd           = '0;
    req_stall     = 1'b1;
    unique case (state)
      S_IDLE: begin
        // no request is taken while reset is held
        req_stall = rst;
        if (req_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // result register must be free or emptied this cycle
        if (!out_full || take) begin
          cmd.exec      = 1'b1;
          out_full_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

### src/ltw_dp.sv
module ltw_dp
  import ltw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  req_t req,
  output rsp_t rsp
);

  entry_t                mem [NUM_LOCKS];
  logic [NUM_LOCKS-1:0]  vld;
  req_t                  cur;
  entry_t                rd_entry;
  logic                  rd_vld;

  entry_t                e, nxt;
  rsp_t                  res;
  logic                  in_range;
  logic [NUM_CLIENTS-1:0] bit_c;
  logic [NUM_CLIENTS-1:0] left;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur      <= req;
      rd_entry <= mem[req.lock_index];
      rd_vld   <= vld[req.lock_index];
    end
    if (cmd.exec && in_range) mem[cur.lock_index] <= nxt;
    if (cmd.exec) rsp <= res;
  end

  // entries never written read as unlocked and empty
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.exec && in_range) begin
      vld[cur.lock_index] <= 1'b1;
    end
  end

  assign in_range = ({1'b0, cur.lock_index} < (LOCK_W + 1)'(NUM_LOCKS)) &&
                    ({1'b0, cur.client} < (CLIENT_W + 1)'(NUM_CLIENTS));

  always_comb begin
    e     = rd_vld ? rd_entry : '0;
    nxt   = e;
    bit_c = NUM_CLIENTS'(1) << cur.client;
    left  = e.waiters & ~bit_c;
    res   = '{status: ST_OK, message: MSG_NONE, target: '0};
    if (!in_range) begin
      res.status = ST_RETRY;
    end else if (cur.action == ACT_RELEASE) begin
      nxt.holder_valid = 1'b0;
      nxt.holder       = '0;
      if (e.waiters == '0) begin
        nxt.locked = 1'b0;
      end else if (e.retry_valid) begin
        res.message = MSG_RETRY;
        res.target  = e.retry;
      end
    end else if (!e.locked) begin
      nxt.locked       = 1'b1;
      nxt.holder_valid = 1'b1;
      nxt.holder       = cur.client;
    end else if (e.waiters == '0) begin
      nxt.waiters     = bit_c;
      nxt.retry_valid = 1'b1;
      nxt.retry       = cur.client;
      res.status      = ST_RETRY;
      if (e.holder_valid) begin
        res.message = MSG_REVOKE;
        res.target  = e.holder;
      end
    end else if (!(e.retry_valid && e.waiters[e.retry])) begin
      nxt.waiters = e.waiters | bit_c;
      res.status  = ST_RETRY;
      if (e.holder_valid) begin
        res.message = MSG_REVOKE;
        res.target  = e.holder;
      end
    end else if (e.retry == cur.client) begin
      nxt.holder_valid = 1'b1;
      nxt.holder       = cur.client;
      nxt.waiters      = left;
      if (left == '0) begin
        nxt.retry_valid = 1'b0;
        nxt.retry       = '0;
      end else begin
        nxt.retry   = lowest_waiter(left);
        res.message = MSG_REVOKE;
        res.target  = cur.client;
      end
    end else begin
      nxt.waiters = e.waiters | bit_c;
      res.status  = ST_RETRY;
    end
  end

endmodule

### src/ltw_checker.sv
module ltw_checker
  import ltw_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  logic [1:0] pending;
  logic       req_acc, rsp_acc;

  assign req_acc = req_valid && !req_stall;
  assign rsp_acc = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_acc) - 2'(rsp_acc);
    end
  end

  // at most one item in update and one waiting in the response register
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("more than two items outstanding");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response item without request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_no_msg_target: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.message == MSG_NONE |-> rsp.target == '0)
    else $error("target set without message");

  a_retry_msg_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.message == MSG_RETRY |-> rsp.status == ST_OK)
    else $error("retry message with retry status");

endmodule

bind lock_table_with_waiters ltw_checker u_ltw_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
